// ===== rtl/core/md4_pkg.sv =====
// ----------------------------------------------------------------------------
// md4_pkg
// Shared constants, types and step functions for the MD4 block compression
// core: rotate amounts, round constants, word order and the command word
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package md4_pkg;

  // Word and index widths.
  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = 16;
  localparam int WIDX_W     = 4;
  localparam int STEP_W     = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [WIDX_W-1:0] LAST_WORD = 4'd15;
  localparam logic [STEP_W-1:0] LAST_STEP = 6'd47;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_D = 2'd3;

  // Reset values of the initial chaining words.
  localparam logic [WORD_W-1:0] INIT_A_RST = 32'h6745_2301;
  localparam logic [WORD_W-1:0] INIT_B_RST = 32'hEFCD_AB89;
  localparam logic [WORD_W-1:0] INIT_C_RST = 32'h98BA_DCFE;
  localparam logic [WORD_W-1:0] INIT_D_RST = 32'h1032_5476;

  // Round codes.
  localparam logic [1:0] RND_F = 2'd0;
  localparam logic [1:0] RND_G = 2'd1;
  localparam logic [1:0] RND_H = 2'd2;

  // Round constants.
  localparam logic [WORD_W-1:0] K_F = 32'h0000_0000;
  localparam logic [WORD_W-1:0] K_G = 32'h5A82_7999;
  localparam logic [WORD_W-1:0] K_H = 32'h6ED9_EBA1;

  // Rotate amounts.
  localparam logic [4:0] MD4_S11 = 5'd3;
  localparam logic [4:0] MD4_S12 = 5'd7;
  localparam logic [4:0] MD4_S13 = 5'd11;
  localparam logic [4:0] MD4_S14 = 5'd19;
  localparam logic [4:0] MD4_S21 = 5'd3;
  localparam logic [4:0] MD4_S22 = 5'd5;
  localparam logic [4:0] MD4_S23 = 5'd9;
  localparam logic [4:0] MD4_S24 = 5'd13;
  localparam logic [4:0] MD4_S31 = 5'd3;
  localparam logic [4:0] MD4_S32 = 5'd9;
  localparam logic [4:0] MD4_S33 = 5'd11;
  localparam logic [4:0] MD4_S34 = 5'd15;

  // Command word from the controller to the datapath.
  typedef struct packed {
    logic              wr_en;     // store an incoming word
    logic [WIDX_W-1:0] wr_idx;    // buffer slot for it
    logic              reload;    // reload chaining value from init registers
    logic              start;     // load working values from chaining value
    logic              step;      // run one compression step
    logic [STEP_W-1:0] step_idx;  // step number, 0 to 47
    logic              finish;    // fold working values in and load the output
  } md4_cmd_t;

  // Buffer slot read by a given step.
  function automatic logic [WIDX_W-1:0] md4_word_idx(input logic [1:0] rnd,
                                                     input logic [WIDX_W-1:0] i);
    logic [WIDX_W-1:0] idx;
    case (rnd)
      RND_F:   idx = i;
      RND_G:   idx = {i[1:0], i[3:2]};
      default: idx = {i[0], i[1], i[2], i[3]};
    endcase
    return idx;
  endfunction

  // Rotate amount for a given step.
  function automatic logic [4:0] md4_rot(input logic [1:0] rnd, input logic [1:0] i);
    logic [4:0] s;
    case ({rnd, i})
      {RND_F, 2'd0}: s = MD4_S11;
      {RND_F, 2'd1}: s = MD4_S12;
      {RND_F, 2'd2}: s = MD4_S13;
      {RND_F, 2'd3}: s = MD4_S14;
      {RND_G, 2'd0}: s = MD4_S21;
      {RND_G, 2'd1}: s = MD4_S22;
      {RND_G, 2'd2}: s = MD4_S23;
      {RND_G, 2'd3}: s = MD4_S24;
      {RND_H, 2'd0}: s = MD4_S31;
      {RND_H, 2'd1}: s = MD4_S32;
      {RND_H, 2'd2}: s = MD4_S33;
      default:       s = MD4_S34;
    endcase
    return s;
  endfunction

  // Boolean function of each round.
  function automatic logic [WORD_W-1:0] md4_fn(input logic [1:0] rnd,
                                               input logic [WORD_W-1:0] x,
                                               input logic [WORD_W-1:0] y,
                                               input logic [WORD_W-1:0] z);
    logic [WORD_W-1:0] f;
    case (rnd)
      RND_F:   f = (x & y) | (~x & z);
      RND_G:   f = (x & y) | (x & z) | (y & z);
      default: f = x ^ y ^ z;
    endcase
    return f;
  endfunction

  // Additive constant of each round.
  function automatic logic [WORD_W-1:0] md4_const(input logic [1:0] rnd);
    logic [WORD_W-1:0] k;
    case (rnd)
      RND_F:   k = K_F;
      RND_G:   k = K_G;
      default: k = K_H;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/md4_ctrl.sv =====
// ----------------------------------------------------------------------------
// md4_ctrl
// Controller: counts incoming words, sequences the 48 compression steps and
// owns the valid/stall handshakes of both channels.
// ----------------------------------------------------------------------------
module md4_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_new_message,
  output logic              out_valid,
  input  logic              out_stall,
  output md4_pkg::md4_cmd_t cmd
);
  import md4_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [WIDX_W-1:0] count_r, count_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic [WIDX_W-1:0] wr_idx;
  logic              out_free;

  // Words are taken only while no block is being compressed.
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_idx   = in_new_message ? '0 : count_r;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    step_nxt     = step_r;
    cmd          = '0;
    cmd.wr_idx   = wr_idx;
    cmd.step_idx = step_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.wr_en  = 1'b1;
          cmd.reload = in_new_message;
          if (wr_idx == LAST_WORD) begin
            count_nxt = '0;
            step_nxt  = '0;
            cmd.start = 1'b1;
            state_nxt = ST_RUN;
          end else begin
            count_nxt = wr_idx + 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait until the output register is free, then fold in and publish.
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output word valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/md4_datapath.sv =====
// ----------------------------------------------------------------------------
// md4_datapath
// Datapath: block word buffer, initial and chaining registers, the four
// working registers with one MD4 step per cycle, and the output register.
// ----------------------------------------------------------------------------
module md4_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  md4_pkg::md4_cmd_t          cmd,
  input  logic [md4_pkg::WORD_W-1:0] in_message_word,
  input  logic                       cfg_we,
  input  logic [md4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [md4_pkg::WORD_W-1:0] cfg_wdata,
  output logic [md4_pkg::WORD_W-1:0] out_digest_a,
  output logic [md4_pkg::WORD_W-1:0] out_digest_b,
  output logic [md4_pkg::WORD_W-1:0] out_digest_c,
  output logic [md4_pkg::WORD_W-1:0] out_digest_d
);
  import md4_pkg::*;

  logic [WORD_W-1:0] words_r [NUM_WORDS];
  logic [WORD_W-1:0] init_a_r, init_b_r, init_c_r, init_d_r;
  logic [WORD_W-1:0] chain_a_r, chain_b_r, chain_c_r, chain_d_r;
  logic [WORD_W-1:0] chain_a_nxt, chain_b_nxt, chain_c_nxt, chain_d_nxt;
  logic [WORD_W-1:0] work_a_r, work_b_r, work_c_r, work_d_r;
  logic [WORD_W-1:0] dig_a_r, dig_b_r, dig_c_r, dig_d_r;
  logic [1:0]        rnd;
  logic [WIDX_W-1:0] widx;
  logic [4:0]        rot;
  logic [WORD_W-1:0] sum;
  logic [2*WORD_W-1:0] rot_wide;
  logic [WORD_W-1:0] step_nxt;

  // One MD4 step: four-way add, then rotate left.
  assign rnd      = cmd.step_idx[5:4];
  assign widx     = md4_word_idx(rnd, cmd.step_idx[3:0]);
  assign rot      = md4_rot(rnd, cmd.step_idx[1:0]);
  assign sum      = work_a_r + md4_fn(rnd, work_b_r, work_c_r, work_d_r)
                  + words_r[widx] + md4_const(rnd);
  assign rot_wide = {sum, sum} << rot;
  assign step_nxt = rot_wide[2*WORD_W-1:WORD_W];

  // Chaining value after the block is folded in.
  assign chain_a_nxt = chain_a_r + work_a_r;
  assign chain_b_nxt = chain_b_r + work_b_r;
  assign chain_c_nxt = chain_c_r + work_c_r;
  assign chain_d_nxt = chain_d_r + work_d_r;

  // Block word buffer.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      words_r[cmd.wr_idx] <= in_message_word;
    end
  end

  // Initial chaining words, written through the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_a_r <= INIT_A_RST;
      init_b_r <= INIT_B_RST;
      init_c_r <= INIT_C_RST;
      init_d_r <= INIT_D_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INIT_A: init_a_r <= cfg_wdata;
        CFG_INIT_B: init_b_r <= cfg_wdata;
        CFG_INIT_C: init_c_r <= cfg_wdata;
        CFG_INIT_D: init_d_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Chaining value: reloaded on a new message, updated after each block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_a_r <= INIT_A_RST;
      chain_b_r <= INIT_B_RST;
      chain_c_r <= INIT_C_RST;
      chain_d_r <= INIT_D_RST;
    end else if (cmd.reload) begin
      chain_a_r <= init_a_r;
      chain_b_r <= init_b_r;
      chain_c_r <= init_c_r;
      chain_d_r <= init_d_r;
    end else if (cmd.finish) begin
      chain_a_r <= chain_a_nxt;
      chain_b_r <= chain_b_nxt;
      chain_c_r <= chain_c_nxt;
      chain_d_r <= chain_d_nxt;
    end
  end

  // Working registers; roles rotate every step.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      work_a_r <= chain_a_r;
      work_b_r <= chain_b_r;
      work_c_r <= chain_c_r;
      work_d_r <= chain_d_r;
    end else if (cmd.step) begin
      work_a_r <= work_d_r;
      work_d_r <= work_c_r;
      work_c_r <= work_b_r;
      work_b_r <= step_nxt;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dig_a_r <= chain_a_nxt;
      dig_b_r <= chain_b_nxt;
      dig_c_r <= chain_c_nxt;
      dig_d_r <= chain_d_nxt;
    end
  end

  assign out_digest_a = dig_a_r;
  assign out_digest_b = dig_b_r;
  assign out_digest_c = dig_c_r;
  assign out_digest_d = dig_d_r;

endmodule

// ===== rtl/core/md4_block_compression.sv =====
// Latency: the digest word of a block is valid once its sixteenth word is accepted, the
// 48 steps have run and the output register is free to fold in and load the result.
// Throughput: one message word per cycle for words 0 to 15; no word is taken while
// a block is compressed by the single shared step unit running 48 steps.
// Reset (synchronous, rst_n low) clears the controller, restores the initial
// and chaining words to their standard values and leaves the output empty.
// ----------------------------------------------------------------------------
// md4_block_compression
// MD4 compression core: buffers 16 message words per block, runs the three
// MD4 rounds one step per cycle and emits the updated chaining value.
// ----------------------------------------------------------------------------
module md4_block_compression (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [md4_pkg::WORD_W-1:0]    in_message_word,
  input  logic                          in_new_message,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [md4_pkg::WORD_W-1:0]    out_digest_a,
  output logic [md4_pkg::WORD_W-1:0]    out_digest_b,
  output logic [md4_pkg::WORD_W-1:0]    out_digest_c,
  output logic [md4_pkg::WORD_W-1:0]    out_digest_d,
  input  logic                          cfg_we,
  input  logic [md4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [md4_pkg::WORD_W-1:0]    cfg_wdata
);
  import md4_pkg::*;

  md4_cmd_t cmd;

  // Sequencer and handshakes.
  md4_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_new_message (in_new_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cmd            (cmd)
  );

  // Storage and step arithmetic.
  md4_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_message_word (in_message_word),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_digest_a    (out_digest_a),
    .out_digest_b    (out_digest_b),
    .out_digest_c    (out_digest_c),
    .out_digest_d    (out_digest_d)
  );

endmodule

// ===== tb/tb_md4_block_compression.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_md4_block_compression
// Self-checking testbench for the MD4 block compression core. Message words
// are streamed in bursts. The receiver stalls in patterns of its own, with
// a long hold-off that backs the core up. A scoreboard recomputes every block
// digest in software and compares it with the core's output. The initial
// chaining words are reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------

// Four chaining words: index 0 is A, index 3 is D.
typedef logic [3:0][31:0] md4_chain_t;

// Software predictor of the core and queue of the digests still to come.
class md4_digest_scoreboard;
  md4_chain_t init_words;
  md4_chain_t chain;
  logic [31:0] block_buf [16];
  logic [3:0] fill;
  md4_chain_t expected_digests [$];
  int unsigned errors;

  byte unsigned word_sel [3][16] = '{
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
    '{0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15},
    '{0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15}
  };
  logic [4:0] shift_by [3][4] = '{
    '{md4_pkg::MD4_S11, md4_pkg::MD4_S12, md4_pkg::MD4_S13, md4_pkg::MD4_S14},
    '{md4_pkg::MD4_S21, md4_pkg::MD4_S22, md4_pkg::MD4_S23, md4_pkg::MD4_S24},
    '{md4_pkg::MD4_S31, md4_pkg::MD4_S32, md4_pkg::MD4_S33, md4_pkg::MD4_S34}
  };
  logic [31:0] round_add [3] = '{md4_pkg::K_F, md4_pkg::K_G, md4_pkg::K_H};

  function new();
    init_words[0] = md4_pkg::INIT_A_RST;
    init_words[1] = md4_pkg::INIT_B_RST;
    init_words[2] = md4_pkg::INIT_C_RST;
    init_words[3] = md4_pkg::INIT_D_RST;
    chain = init_words;
    fill = '0;
    errors = 0;
  endfunction

  // A register write only changes what the next new message loads.
  function void set_init(logic [md4_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    init_words[idx] = value;
  endfunction

  function int unsigned pending();
    return expected_digests.size();
  endfunction

  // Run the 48 steps over the buffered block and fold them into the chain.
  function void compress_block();
    logic [31:0] a, b, c, d, mix, sum, rotated;
    logic [1:0] rnd;
    logic [4:0] s;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int r = 0; r < 3; r++) begin
      rnd = 2'(r);
      for (int i = 0; i < 16; i++) begin
        case (rnd)
          md4_pkg::RND_F: mix = (b & c) | (~b & d);
          md4_pkg::RND_G: mix = (b & c) | (b & d) | (c & d);
          default:        mix = b ^ c ^ d;
        endcase
        sum = a + mix + block_buf[word_sel[r][i]] + round_add[r];
        s = shift_by[r][i % 4];
        rotated = (sum << s) | (sum >> (32 - s));
        a = d;
        d = c;
        c = b;
        b = rotated;
      end
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endfunction

  // Note an accepted message word; the sixteenth word of a block yields a digest.
  function void note_word(logic [31:0] word, logic fresh);
    if (fresh) begin
      chain = init_words;
      fill = '0;
    end
    block_buf[fill] = word;
    if (fill != md4_pkg::LAST_WORD) begin
      fill = fill + 4'd1;
      return;
    end
    fill = '0;
    compress_block();
    expected_digests.push_back(chain);
  endfunction

  // Compare an accepted digest with the oldest one predicted.
  function void check_digest(md4_chain_t got);
    md4_chain_t want;
    string field_name [4] = '{"digest_a", "digest_b", "digest_c", "digest_d"};
    if (expected_digests.size() == 0) begin
      $error("unexpected digest %h %h %h %h", got[0], got[1], got[2], got[3]);
      errors++;
      return;
    end
    want = expected_digests.pop_front();
    for (int k = 0; k < 4; k++) begin
      if (got[k] !== want[k]) begin
        $error("%s: expected %h, got %h", field_name[k], want[k], got[k]);
        errors++;
      end
    end
  endfunction
endclass

module tb_md4_block_compression;

  localparam int ITEM_TARGET   = 1500;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;

  typedef enum int {INITS_ZERO, INITS_ONES, INITS_STANDARD, INITS_RANDOM} init_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_message_word = '0;
  logic        in_new_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_a;
  logic [31:0] out_digest_b;
  logic [31:0] out_digest_c;
  logic [31:0] out_digest_d;
  logic        cfg_we = 1'b0;
  logic [md4_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  md4_digest_scoreboard sb = new();
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned pause_count = 0;
  bit          traffic_on = 1'b0;

  md4_block_compression u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_message_word (in_message_word),
    .in_new_message  (in_new_message),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_a    (out_digest_a),
    .out_digest_b    (out_digest_b),
    .out_digest_c    (out_digest_c),
    .out_digest_d    (out_digest_d),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Offer one word and hold it until accepted. Bursts of random length are
  // separated by random gaps. Called and returns at a rising edge.
  task automatic put_word(input logic [31:0] word, input logic fresh);
    int unsigned gap;
    bit taken;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_message_word <= word;
    in_new_message  <= fresh;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    sb.note_word(word, fresh);
    words_sent++;
  endtask

  // Stop sending and wait until every predicted digest has come out.
  task automatic settle_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_init(input logic [md4_pkg::CFG_IDX_W-1:0] idx,
                            input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_init(idx, value);
  endtask

  task automatic program_inits(input init_style_t style);
    md4_chain_t vals;
    for (int k = 0; k < 4; k++) begin
      case (style)
        INITS_ZERO: vals[k] = '0;
        INITS_ONES: vals[k] = '1;
        default:    vals[k] = $urandom;
      endcase
    end
    if (style == INITS_STANDARD) begin
      vals[0] = md4_pkg::INIT_A_RST;
      vals[1] = md4_pkg::INIT_B_RST;
      vals[2] = md4_pkg::INIT_C_RST;
      vals[3] = md4_pkg::INIT_D_RST;
    end
    write_init(md4_pkg::CFG_INIT_A, vals[0]);
    write_init(md4_pkg::CFG_INIT_B, vals[1]);
    write_init(md4_pkg::CFG_INIT_C, vals[2]);
    write_init(md4_pkg::CFG_INIT_D, vals[3]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the core, then usually move the initial words to the next setting.
  task automatic pause_and_reconfigure();
    settle_idle();
    if ($urandom_range(0, 3) != 0) begin
      program_inits(init_style_t'(pause_count % 4));
      pause_count++;
    end
  endtask

  // Message word with extra weight on all-zero, all-one and single-bit words.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // A well-formed message: new-message flag on the first word, whole blocks.
  // Occasionally the core is drained and reprogrammed between blocks, which
  // must not disturb the chaining value of the message in progress.
  task automatic send_message(input int unsigned blocks);
    for (int blk = 0; blk < blocks; blk++) begin
      if (blk > 0 && $urandom_range(0, 5) == 0) pause_and_reconfigure();
      for (int w = 0; w < 16; w++) put_word(pick_word(), (blk == 0 && w == 0));
    end
  endtask

  // Main stimulus.
  initial begin : stimulus
    int unsigned choice;
    int unsigned len;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // A first block with no new-message flag runs on the reset chaining words.
    put_word(32'h0000_0000, 1'b0);
    put_word(32'hFFFF_FFFF, 1'b0);
    put_word(32'h8000_0000, 1'b0);
    put_word(32'h0000_0001, 1'b0);
    put_word(32'h7FFF_FFFF, 1'b0);
    for (int w = 5; w < 16; w++) put_word($urandom, 1'b0);

    // Part of a fresh message, then new initial words while it is a quarter full.
    put_word($urandom, 1'b1);
    for (int w = 0; w < 3; w++) put_word($urandom, 1'b0);
    settle_idle();
    program_inits(INITS_ONES);

    // New message in mid-block: the partial block is dropped.
    put_word(32'hFFFF_FFFF, 1'b1);

    // Random traffic: mostly whole messages, some cut short, some noise.
    traffic_on = 1'b1;
    while (words_sent < ITEM_TARGET) begin
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        send_message($urandom_range(1, 3));
      end else if (choice < 9) begin
        len = $urandom_range(1, 15);
        put_word(pick_word(), 1'b1);
        for (int w = 1; w < len; w++) put_word(pick_word(), 1'b0);
      end else begin
        len = $urandom_range(1, 24);
        for (int w = 0; w < len; w++)
          put_word(pick_word(), ($urandom_range(0, 7) == 0));
      end
      if ($urandom_range(0, 9) == 0) pause_and_reconfigure();
    end

    settle_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** md4_block_compression: PASSED **");
    end else begin
      $display("** md4_block_compression: FAILED **");
    end
    $finish;
  end

  // Receiver stall patterns, with a long hold-off once traffic is running.
  initial begin : receiver_stall
    int unsigned style;
    int unsigned seg_len;
    bit held_once;
    held_once = 1'b0;
    forever begin
      style = $urandom_range(0, 19);
      seg_len = $urandom_range(5, 60);
      if (traffic_on && !held_once) style = 0;
      if (style == 0 && traffic_on) begin
        held_once = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        repeat (seg_len) begin
          if (style < 7) out_stall <= 1'b0;
          else if (style < 12) out_stall <= $urandom_range(0, 1);
          else if (style < 16) out_stall <= ~out_stall;
          else out_stall <= ($urandom_range(0, 4) != 0);
          @(posedge clk);
        end
      end
    end
  end

  // Digest monitor: sample mid-cycle, check at the accepting edge.
  initial begin : digest_monitor
    bit hit;
    md4_chain_t got;
    forever begin
      @(negedge clk);
      hit = rst_n && out_valid && !out_stall;
      got = {out_digest_d, out_digest_c, out_digest_b, out_digest_a};
      @(posedge clk);
      if (hit) sb.check_digest(got);
    end
  end

  // Run limit.
  initial begin : run_limit
    #10_000_000;
    $display("** md4_block_compression: FAILED **");
    $finish;
  end

endmodule
